@@ rtl/dca_pkg.sv @@
// descriptor chain allocator: shared types and constants
// operation and status codes, state encoding and fixed field widths
// no dependencies
package dca_pkg;

    localparam int HEAD_W    = 4;
    localparam int IDX_OUT_W = 3;
    localparam int COUNT_W   = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_SPACE     = 2'd1,
        STATUS_RANGE        = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_PICK,
        ST_ALLOC_LAST,
        ST_FREE_CHECK,
        ST_FREE_READ,
        ST_DONE
    } t_state;

endpackage

@@ rtl/dca_intf.sv @@
// request and response channel interfaces of the descriptor chain allocator
// valid/ready handshake with the payload fields alongside
// depends on dca_pkg
interface dca_req_if;
    logic                          valid;
    logic                          ready;
    dca_pkg::t_op                  operation;
    logic [dca_pkg::HEAD_W-1:0]    head_index;

    modport source (output valid, output operation, output head_index, input ready);
    modport sink   (input valid, input operation, input head_index, output ready);
endinterface

interface dca_rsp_if;
    logic                          valid;
    logic                          ready;
    dca_pkg::t_status              status;
    logic [dca_pkg::IDX_OUT_W-1:0] first_index;
    logic [dca_pkg::IDX_OUT_W-1:0] second_index;
    logic [dca_pkg::IDX_OUT_W-1:0] third_index;
    logic [dca_pkg::COUNT_W-1:0]   freed_count;

    modport source (output valid, output status, output first_index, output second_index,
                    output third_index, output freed_count, input ready);
    modport sink   (input valid, input status, input first_index, input second_index,
                    input third_index, input freed_count, output ready);
endinterface

@@ rtl/descriptor_chain_allocator_core.sv @@
// descriptor chain allocator top level
// free map in flip-flops, next links in a synchronous memory, one sequencer
// depends on dca_pkg and the channel interfaces in dca_intf.sv
//
// Usage:
//   i_req carries one request per transfer: allocate a chain of CHAIN_LENGTH
//   descriptors, or free the chain that starts at head_index. o_rsp returns one
//   response per request, in order, with the status, the allocated indices and
//   the number of descriptors released.
//   One request is worked on at a time. An allocate makes one priority pick per
//   cycle in the pick state, then writes the tail link and commits the free map
//   in the last state. A free visits each chain entry in a check state and then
//   a read state, which waits for the registered read of the link memory.
//   The response sits in an output register, so the next request is taken
//   while it waits; if the receiver stalls with a response already held, the
//   finished request waits in the done state and i_req.ready stays low.
//   Reset marks every descriptor free and empties the response register. The
//   link memory needs no clearing: a link is only read for an allocated entry,
//   and the allocate has always written it.
module descriptor_chain_allocator_core #(
    parameter int NUM_DESCRIPTORS = 8,
    parameter int CHAIN_LENGTH    = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dca_req_if.sink        i_req,
    dca_rsp_if.source      o_rsp
);

    localparam int IW  = $clog2(NUM_DESCRIPTORS);
    localparam int CUW = (IW > dca_pkg::HEAD_W) ? IW : dca_pkg::HEAD_W;
    localparam int SW  = $clog2(NUM_DESCRIPTORS + 1);
    localparam int PCW = $clog2(CHAIN_LENGTH + 1);
    localparam int PIW = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
    localparam int CW  = dca_pkg::COUNT_W;
    localparam int OW  = dca_pkg::IDX_OUT_W;

    dca_pkg::t_state  r_state, n_state;
    logic [NUM_DESCRIPTORS-1:0] r_free_map, n_free_map;
    logic [NUM_DESCRIPTORS-1:0] r_scan, n_scan;
    logic [IW-1:0]    r_pick [CHAIN_LENGTH];
    logic [IW-1:0]    n_pick [CHAIN_LENGTH];
    logic [PCW-1:0]   r_k, n_k;
    logic [CUW-1:0]   r_cur, n_cur;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_steps, n_steps;
    dca_pkg::t_op     r_op, n_op;
    dca_pkg::t_status r_status, n_status;

    logic             r_out_valid, n_out_valid;
    dca_pkg::t_status r_out_status, n_out_status;
    logic [OW-1:0]    r_out_first, n_out_first;
    logic [OW-1:0]    r_out_second, n_out_second;
    logic [OW-1:0]    r_out_third, n_out_third;
    logic [CW-1:0]    r_out_count, n_out_count;

    // link memory entry: {next flag, next index}
    logic [IW:0]      r_link_mem [NUM_DESCRIPTORS];
    logic [IW:0]      r_rd_data;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    logic [IW:0]      w_wdata;
    logic [IW-1:0]    w_raddr;

    logic [IW-1:0]    w_low_idx;
    logic             w_low_found;
    logic [IW-1:0]    w_cur_idx;
    logic             w_cur_oob;
    logic             w_out_free;
    logic [OW-1:0]    w_idx3 [3];

    assign w_cur_idx  = r_cur[IW-1:0];
    assign w_cur_oob  = ({1'b0, r_cur} >= (CUW + 1)'(NUM_DESCRIPTORS));
    assign w_raddr    = w_cur_idx;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // lowest free descriptor still unpicked
    always_comb begin
        w_low_idx   = '0;
        w_low_found = 1'b0;
        for (int i = NUM_DESCRIPTORS - 1; i >= 0; i--) begin
            if (r_scan[i]) begin
                w_low_idx   = IW'(i);
                w_low_found = 1'b1;
            end
        end
    end

    // picks masked to the three-bit response fields, zero where no pick exists
    for (genvar g = 0; g < 3; g++) begin : g_idx
        if (g < CHAIN_LENGTH) begin : g_pick
            logic [IW+2:0] w_ext;
            assign w_ext     = {3'b000, r_pick[g]};
            assign w_idx3[g] = w_ext[OW-1:0];
        end else begin : g_none
            assign w_idx3[g] = '0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dca_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.operation == dca_pkg::OP_ALLOC) ?
                              dca_pkg::ST_ALLOC_PICK : dca_pkg::ST_FREE_CHECK;
                end
            end
            dca_pkg::ST_ALLOC_PICK: begin
                if (!w_low_found) begin
                    n_state = dca_pkg::ST_DONE;
                end else if (r_k == PCW'(CHAIN_LENGTH - 1)) begin
                    n_state = dca_pkg::ST_ALLOC_LAST;
                end
            end
            dca_pkg::ST_ALLOC_LAST: begin
                n_state = dca_pkg::ST_DONE;
            end
            dca_pkg::ST_FREE_CHECK: begin
                if (w_cur_oob || r_free_map[w_cur_idx]) begin
                    n_state = dca_pkg::ST_DONE;
                end else begin
                    n_state = dca_pkg::ST_FREE_READ;
                end
            end
            dca_pkg::ST_FREE_READ: begin
                if (r_rd_data[IW] && r_steps != SW'(NUM_DESCRIPTORS)) begin
                    n_state = dca_pkg::ST_FREE_CHECK;
                end else begin
                    n_state = dca_pkg::ST_DONE;
                end
            end
            dca_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = dca_pkg::ST_IDLE;
                end
            end
            default: n_state = dca_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_free_map   = r_free_map;
        n_scan       = r_scan;
        n_pick       = r_pick;
        n_k          = r_k;
        n_cur        = r_cur;
        n_count      = r_count;
        n_steps      = r_steps;
        n_op         = r_op;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_third  = r_out_third;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid;
        w_we         = 1'b0;
        w_waddr      = r_pick[0];
        w_wdata      = '0;
        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            dca_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.operation;
                    n_scan   = r_free_map;
                    n_k      = '0;
                    n_cur    = CUW'(i_req.head_index);
                    n_count  = '0;
                    n_steps  = '0;
                    n_status = dca_pkg::STATUS_OK;
                end
            end
            dca_pkg::ST_ALLOC_PICK: begin
                if (!w_low_found) begin
                    n_status = dca_pkg::STATUS_NO_SPACE;
                end else begin
                    n_pick[r_k[PIW-1:0]] = w_low_idx;
                    n_scan[w_low_idx]    = 1'b0;
                    n_k                  = r_k + 1'b1;
                    // link the previous pick to this one; harmless if the
                    // allocate later fails, as the entry stays free
                    if (r_k != '0) begin
                        w_we    = 1'b1;
                        w_waddr = r_pick[PIW'(r_k - 1'b1)];
                        w_wdata = {1'b1, w_low_idx};
                    end
                end
            end
            dca_pkg::ST_ALLOC_LAST: begin
                w_we       = 1'b1;
                w_waddr    = r_pick[CHAIN_LENGTH-1];
                w_wdata    = '0;
                n_free_map = r_scan;
                n_status   = dca_pkg::STATUS_OK;
            end
            dca_pkg::ST_FREE_CHECK: begin
                if (w_cur_oob) begin
                    n_status = dca_pkg::STATUS_RANGE;
                end else if (r_free_map[w_cur_idx]) begin
                    n_status = dca_pkg::STATUS_ALREADY_FREE;
                end else begin
                    n_free_map[w_cur_idx] = 1'b1;
                    n_count = (r_count == dca_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
                    n_steps = r_steps + 1'b1;
                end
            end
            dca_pkg::ST_FREE_READ: begin
                n_cur = CUW'(r_rd_data[IW-1:0]);
            end
            dca_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    if (r_op == dca_pkg::OP_ALLOC && r_status == dca_pkg::STATUS_OK) begin
                        n_out_first  = w_idx3[0];
                        n_out_second = w_idx3[1];
                        n_out_third  = w_idx3[2];
                    end else begin
                        n_out_first  = '0;
                        n_out_second = '0;
                        n_out_third  = '0;
                    end
                    n_out_count = (r_op == dca_pkg::OP_FREE) ? r_count : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dca_pkg::ST_IDLE;
            r_free_map  <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_map  <= n_free_map;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_pick       <= n_pick;
        r_k          <= n_k;
        r_cur        <= n_cur;
        r_count      <= n_count;
        r_steps      <= n_steps;
        r_op         <= n_op;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_third  <= n_out_third;
        r_out_count  <= n_out_count;
    end

    // link memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_link_mem[w_raddr];
    end

    assign i_req.ready        = (r_state == dca_pkg::ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.first_index  = r_out_first;
    assign o_rsp.second_index = r_out_second;
    assign o_rsp.third_index  = r_out_third;
    assign o_rsp.freed_count  = r_out_count;

`ifndef SYNTHESIS
    a_alloc_picks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dca_pkg::ST_ALLOC_LAST) |->
        ($countones(r_free_map) - $countones(r_scan) == CHAIN_LENGTH))
        else $error("allocate did not take exactly one chain of descriptors");

    a_free_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dca_pkg::ST_FREE_READ) |->
        ($countones(r_free_map) == $countones($past(r_free_map)) + 1))
        else $error("free step did not release exactly one descriptor");

    a_no_space_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dca_pkg::ST_DONE && r_op == dca_pkg::OP_ALLOC &&
         r_status == dca_pkg::STATUS_NO_SPACE) |->
        ($countones(r_free_map) < CHAIN_LENGTH))
        else $error("no space reported with enough free descriptors");

    a_link_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dca_pkg::ST_FREE_READ && r_rd_data[IW]) |->
        ({1'b0, r_rd_data[IW-1:0]} < (IW + 1)'(NUM_DESCRIPTORS)))
        else $error("allocated entry holds a link past the descriptor count");
`endif

endmodule
